// File: rtl/ppmds_pkg.sv
// ----------------------------------------------------------------------------
// ppmds_pkg
// Shared types, codes and helpers of the planar point mass drag step unit.
// ----------------------------------------------------------------------------
package ppmds_pkg;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 128;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VEL   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUAD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THR     = 3'd5;

    localparam logic        MODE_ACCEL      = 1'b0;
    localparam logic [30:0] RST_MAX_ACC     = 31'd655360;
    localparam logic [30:0] RST_MAX_VEL     = 31'd655360;
    localparam logic [30:0] RST_LIN_GAIN    = 31'd6554;
    localparam logic [30:0] RST_QUAD_GAIN   = 31'd655;
    localparam logic [30:0] RST_THRESHOLD   = 31'd327680;
    localparam logic [16:0] ONE_Q16         = 17'd65536;
    localparam logic [63:0] SQRT_TOP_BIT    = 64'h4000_0000_0000_0000;

    localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
    localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_SQY, ST_SUM, ST_SQRT, ST_ALPHA, ST_DIV, ST_AEND,
        ST_CLAMP, ST_CMUL, ST_CDLD, ST_CSTORE, ST_CWR,
        ST_LIN_M, ST_LIN, ST_SQ, ST_MIXL, ST_QUAD, ST_MIXQ_M, ST_DRAG,
        ST_VW_M, ST_VW, ST_VA_M, ST_VA, ST_P_M, ST_P, ST_DONE
    } state_t;

    function automatic logic [31:0] sat32(input logic signed [51:0] v);
        logic [31:0] r;
        if (v > SAT_MAX)
            r = 32'h7FFF_FFFF;
        else if (v < SAT_MIN)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [32:0] mag33(input logic [32:0] v);
        logic [32:0] r;
        r = v[32] ? (33'd0 - v) : v;
        return r;
    endfunction

    function automatic logic signed [51:0] sx32(input logic [31:0] v);
        logic signed [51:0] r;
        r = $signed({{20{v[31]}}, v});
        return r;
    endfunction

endpackage

// File: rtl/planar_point_mass_drag_step_unit.sv
// ----------------------------------------------------------------------------
// planar_point_mass_drag_step_unit
// 2D point mass step with wind and blended linear/quadratic drag, Q16.16.
// ----------------------------------------------------------------------------
// Tick: 32-step square root, 16-step alpha divide, then each axis
//   through the shared multiplier, plus output hold.
// Commands: two 31-step divides when clamped. Reset item: applied on accept.
// Throughput: one item at a time; s_tready only in idle. Output register
//   lets the next item start while a result beat waits.
// Reset: async; clears state, position, velocity, acceleration and wind, loads config defaults.
module planar_point_mass_drag_step_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // command_x, command_y, wind_step_x, wind_step_y, time_step
    input  logic [ppmds_pkg::IN_DATA_W-1:0]     s_tdata,
    // kind
    input  logic [ppmds_pkg::KIND_W-1:0]        s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // position_x, position_y, velocity_x, velocity_y
    output logic [ppmds_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                                cfg_we,
    input  logic [ppmds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppmds_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ppmds_pkg::state_t state_reg, state_next;

    logic        mode_reg;
    logic [30:0] max_acc_reg, max_vel_reg, kl_reg, kq_reg, thr_reg;

    logic [31:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [31:0] vel_x_reg, vel_x_next, vel_y_reg, vel_y_next;
    logic [31:0] acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic [31:0] wind_x_reg, wind_x_next, wind_y_reg, wind_y_next;
    logic        axis_reg, axis_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        m_valid_reg, m_valid_next;

    logic [1:0]  kind_reg, kind_next;
    logic [31:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [31:0] wsx_reg, wsx_next, wsy_reg, wsy_next;
    logic [15:0] dt_reg, dt_next;
    logic [64:0] prod_reg, prod_next;
    logic        neg_reg, neg_next;
    logic [63:0] n_reg, n_next, root_reg, root_next, bit_reg, bit_next;
    logic [31:0] rem_reg, rem_next, dvs_reg, dvs_next;
    logic [30:0] num_reg, num_next, q_reg, q_next;
    logic [16:0] alpha_reg, alpha_next;
    logic [32:0] lin_reg, lin_next, quad_reg, quad_next, mix_reg, mix_next;
    logic [31:0] sq_reg, sq_next, drag_reg, drag_next;
    logic [127:0] out_reg, out_next;

    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_neg;

    logic               accept, is_tick, div_ge, sqrt_ge;
    logic [31:0]        v_sel, p_sel, w_sel, a_sel, c_sel, src_x, src_y, c_new, s_tmp;
    logic [30:0]        limit;
    logic [48:0]        prod_shr;
    logic signed [49:0] red;
    logic signed [51:0] red52;
    logic [32:0]        div_sh, wsum;
    logic [63:0]        sqrt_t;
    logic [16:0]        one_m_alpha;

    assign s_tready = (state_reg == ppmds_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    assign is_tick = (kind_reg == ppmds_pkg::KIND_TICK);
    assign v_sel   = axis_reg ? vel_y_reg  : vel_x_reg;
    assign p_sel   = axis_reg ? pos_y_reg  : pos_x_reg;
    assign w_sel   = axis_reg ? wind_y_reg : wind_x_reg;
    assign a_sel   = axis_reg ? acc_y_reg  : acc_x_reg;
    assign c_sel   = axis_reg ? cy_reg     : cx_reg;
    assign src_x   = is_tick ? vel_x_reg : cx_reg;
    assign src_y   = is_tick ? vel_y_reg : cy_reg;
    assign limit   = (kind_reg == ppmds_pkg::KIND_ACCEL) ? max_acc_reg : max_vel_reg;

    assign prod_shr    = prod_reg[64:16];
    assign red         = neg_reg ? -$signed({1'b0, prod_shr}) : $signed({1'b0, prod_shr});
    assign red52       = {{2{red[49]}}, red};
    assign one_m_alpha = ppmds_pkg::ONE_Q16 - alpha_reg;
    assign wsum        = {w_sel[31], w_sel} + {drag_reg[31], drag_reg};

    assign div_sh  = {rem_reg, num_reg[30]};
    assign div_ge  = (div_sh >= {1'b0, dvs_reg});
    assign sqrt_t  = root_reg + bit_reg;
    assign sqrt_ge = (n_reg >= sqrt_t);
    assign c_new   = c_sel[31] ? (32'd0 - {1'b0, q_reg}) : {1'b0, q_reg};

    // shared multiplier, registered
    assign prod_next = 65'(mul_a) * 65'(mul_b);
    assign neg_next  = mul_neg;

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (state_reg)
            ppmds_pkg::ST_START:
            begin
                mul_a = ppmds_pkg::mag33({src_x[31], src_x});
                mul_b = mul_a[31:0];
            end
            ppmds_pkg::ST_SQY:
            begin
                mul_a = ppmds_pkg::mag33({src_y[31], src_y});
                mul_b = mul_a[31:0];
            end
            ppmds_pkg::ST_CMUL:
            begin
                mul_a = ppmds_pkg::mag33({c_sel[31], c_sel});
                mul_b = {1'b0, limit};
            end
            ppmds_pkg::ST_LIN_M:
            begin
                mul_a   = ppmds_pkg::mag33({v_sel[31], v_sel});
                mul_b   = {1'b0, kl_reg};
                mul_neg = v_sel[31];
            end
            ppmds_pkg::ST_LIN:
            begin
                mul_a   = ppmds_pkg::mag33({v_sel[31], v_sel});
                mul_b   = mul_a[31:0];
                mul_neg = v_sel[31];
            end
            ppmds_pkg::ST_SQ:
            begin
                mul_a   = ppmds_pkg::mag33(lin_reg);
                mul_b   = {15'd0, one_m_alpha};
                mul_neg = lin_reg[32];
            end
            ppmds_pkg::ST_MIXL:
            begin
                mul_a   = ppmds_pkg::mag33({sq_reg[31], sq_reg});
                mul_b   = {1'b0, kq_reg};
                mul_neg = sq_reg[31];
            end
            ppmds_pkg::ST_MIXQ_M:
            begin
                mul_a   = ppmds_pkg::mag33(quad_reg);
                mul_b   = {15'd0, alpha_reg};
                mul_neg = quad_reg[32];
            end
            ppmds_pkg::ST_VW_M:
            begin
                mul_a   = ppmds_pkg::mag33(wsum);
                mul_b   = {16'd0, dt_reg};
                mul_neg = wsum[32];
            end
            ppmds_pkg::ST_VA_M:
            begin
                mul_a   = ppmds_pkg::mag33({a_sel[31], a_sel});
                mul_b   = {16'd0, dt_reg};
                mul_neg = a_sel[31];
            end
            ppmds_pkg::ST_P_M:
            begin
                mul_a   = ppmds_pkg::mag33({v_sel[31], v_sel});
                mul_b   = {16'd0, dt_reg};
                mul_neg = v_sel[31];
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppmds_pkg::ST_IDLE:
                if (accept && s_tuser != ppmds_pkg::KIND_RESET &&
                    !(s_tuser == ppmds_pkg::KIND_VEL && mode_reg == ppmds_pkg::MODE_ACCEL))
                    state_next = ppmds_pkg::ST_START;
            ppmds_pkg::ST_START:  state_next = ppmds_pkg::ST_SQY;
            ppmds_pkg::ST_SQY:    state_next = ppmds_pkg::ST_SUM;
            ppmds_pkg::ST_SUM:    state_next = ppmds_pkg::ST_SQRT;
            ppmds_pkg::ST_SQRT:
                if (cnt_reg == 5'd0)
                    state_next = is_tick ? ppmds_pkg::ST_ALPHA : ppmds_pkg::ST_CLAMP;
            ppmds_pkg::ST_ALPHA:
                if (thr_reg == 31'd0 || root_reg[31:0] >= {1'b0, thr_reg})
                    state_next = ppmds_pkg::ST_LIN_M;
                else
                    state_next = ppmds_pkg::ST_DIV;
            ppmds_pkg::ST_DIV:
                if (cnt_reg == 5'd0)
                    state_next = is_tick ? ppmds_pkg::ST_AEND : ppmds_pkg::ST_CSTORE;
            ppmds_pkg::ST_AEND:   state_next = ppmds_pkg::ST_LIN_M;
            ppmds_pkg::ST_CLAMP:
                state_next = (root_reg[31:0] > {1'b0, limit}) ? ppmds_pkg::ST_CMUL
                                                              : ppmds_pkg::ST_CWR;
            ppmds_pkg::ST_CMUL:   state_next = ppmds_pkg::ST_CDLD;
            ppmds_pkg::ST_CDLD:   state_next = ppmds_pkg::ST_DIV;
            ppmds_pkg::ST_CSTORE:
                state_next = axis_reg ? ppmds_pkg::ST_CWR : ppmds_pkg::ST_CMUL;
            ppmds_pkg::ST_CWR:    state_next = ppmds_pkg::ST_IDLE;
            ppmds_pkg::ST_LIN_M:  state_next = ppmds_pkg::ST_LIN;
            ppmds_pkg::ST_LIN:    state_next = ppmds_pkg::ST_SQ;
            ppmds_pkg::ST_SQ:     state_next = ppmds_pkg::ST_MIXL;
            ppmds_pkg::ST_MIXL:   state_next = ppmds_pkg::ST_QUAD;
            ppmds_pkg::ST_QUAD:   state_next = ppmds_pkg::ST_MIXQ_M;
            ppmds_pkg::ST_MIXQ_M: state_next = ppmds_pkg::ST_DRAG;
            ppmds_pkg::ST_DRAG:   state_next = ppmds_pkg::ST_VW_M;
            ppmds_pkg::ST_VW_M:   state_next = ppmds_pkg::ST_VW;
            ppmds_pkg::ST_VW:
                state_next = (mode_reg == ppmds_pkg::MODE_ACCEL) ? ppmds_pkg::ST_VA_M
                                                                 : ppmds_pkg::ST_P_M;
            ppmds_pkg::ST_VA_M:   state_next = ppmds_pkg::ST_VA;
            ppmds_pkg::ST_VA:     state_next = ppmds_pkg::ST_P_M;
            ppmds_pkg::ST_P_M:    state_next = ppmds_pkg::ST_P;
            ppmds_pkg::ST_P:
                state_next = axis_reg ? ppmds_pkg::ST_DONE : ppmds_pkg::ST_LIN_M;
            ppmds_pkg::ST_DONE:
                if (!m_valid_reg || m_tready)
                    state_next = ppmds_pkg::ST_IDLE;
            default:              state_next = ppmds_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        pos_x_next = pos_x_reg;  pos_y_next = pos_y_reg;
        vel_x_next = vel_x_reg;  vel_y_next = vel_y_reg;
        acc_x_next = acc_x_reg;  acc_y_next = acc_y_reg;
        wind_x_next = wind_x_reg; wind_y_next = wind_y_reg;
        axis_next = axis_reg;    cnt_next = cnt_reg;
        kind_next = kind_reg;    cx_next = cx_reg;  cy_next = cy_reg;
        wsx_next = wsx_reg;      wsy_next = wsy_reg; dt_next = dt_reg;
        n_next = n_reg;          root_next = root_reg; bit_next = bit_reg;
        rem_next = rem_reg;      dvs_next = dvs_reg;
        num_next = num_reg;      q_next = q_reg;
        alpha_next = alpha_reg;  lin_next = lin_reg; quad_next = quad_reg;
        mix_next = mix_reg;      sq_next = sq_reg;   drag_next = drag_reg;
        out_next = out_reg;
        s_tmp = '0;
        m_valid_next = m_valid_reg && !m_tready;

        unique case (state_reg)
            ppmds_pkg::ST_IDLE:
                if (accept)
                begin
                    kind_next = s_tuser;
                    cx_next   = s_tdata[31:0];
                    cy_next   = s_tdata[63:32];
                    wsx_next  = s_tdata[95:64];
                    wsy_next  = s_tdata[127:96];
                    dt_next   = s_tdata[143:128];
                    axis_next = 1'b0;
                    if (s_tuser == ppmds_pkg::KIND_RESET)
                    begin
                        pos_x_next = '0; pos_y_next = '0;
                        vel_x_next = '0; vel_y_next = '0;
                        acc_x_next = '0; acc_y_next = '0;
                    end
                end
            ppmds_pkg::ST_START:
                if (is_tick)
                begin
                    wind_x_next = ppmds_pkg::sat32(ppmds_pkg::sx32(wind_x_reg) +
                                                   ppmds_pkg::sx32(wsx_reg));
                    wind_y_next = ppmds_pkg::sat32(ppmds_pkg::sx32(wind_y_reg) +
                                                   ppmds_pkg::sx32(wsy_reg));
                end
            ppmds_pkg::ST_SQY:
                n_next = prod_reg[63:0];
            ppmds_pkg::ST_SUM:
            begin
                n_next    = n_reg + prod_reg[63:0];
                root_next = '0;
                bit_next  = ppmds_pkg::SQRT_TOP_BIT;
                cnt_next  = 5'd31;
            end
            ppmds_pkg::ST_SQRT:
            begin
                if (sqrt_ge)
                begin
                    n_next    = n_reg - sqrt_t;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                    root_next = root_reg >> 1;
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 5'd1;
            end
            ppmds_pkg::ST_ALPHA:
            begin
                alpha_next = ppmds_pkg::ONE_Q16;
                rem_next   = root_reg[31:0];
                num_next   = '0;
                dvs_next   = {1'b0, thr_reg};
                q_next     = '0;
                cnt_next   = 5'd15;
            end
            ppmds_pkg::ST_DIV:
            begin
                rem_next = div_ge ? 32'(div_sh - {1'b0, dvs_reg}) : div_sh[31:0];
                num_next = {num_reg[29:0], 1'b0};
                q_next   = {q_reg[29:0], div_ge};
                cnt_next = cnt_reg - 5'd1;
            end
            ppmds_pkg::ST_AEND:
                alpha_next = {1'b0, q_reg[15:0]};
            ppmds_pkg::ST_CDLD:
            begin
                rem_next = {1'b0, prod_reg[61:31]};
                num_next = prod_reg[30:0];
                dvs_next = root_reg[31:0];
                q_next   = '0;
                cnt_next = 5'd30;
            end
            ppmds_pkg::ST_CSTORE:
            begin
                if (axis_reg)
                    cy_next = c_new;
                else
                    cx_next = c_new;
                axis_next = 1'b1;
            end
            ppmds_pkg::ST_CWR:
                if (kind_reg == ppmds_pkg::KIND_ACCEL)
                begin
                    acc_x_next = cx_reg;
                    acc_y_next = cy_reg;
                end
                else
                begin
                    vel_x_next = cx_reg;
                    vel_y_next = cy_reg;
                end
            ppmds_pkg::ST_LIN:
            begin
                s_tmp    = ppmds_pkg::sat32(red52);
                lin_next = 33'd0 - {s_tmp[31], s_tmp};
            end
            ppmds_pkg::ST_SQ:
                sq_next = ppmds_pkg::sat32(red52);
            ppmds_pkg::ST_MIXL:
                mix_next = red[32:0];
            ppmds_pkg::ST_QUAD:
            begin
                s_tmp     = ppmds_pkg::sat32(red52);
                quad_next = 33'd0 - {s_tmp[31], s_tmp};
            end
            ppmds_pkg::ST_DRAG:
                drag_next = ppmds_pkg::sat32($signed({{19{mix_reg[32]}}, mix_reg}) + red52);
            ppmds_pkg::ST_VW, ppmds_pkg::ST_VA:
            begin
                s_tmp = ppmds_pkg::sat32(ppmds_pkg::sx32(v_sel) + red52);
                if (axis_reg)
                    vel_y_next = s_tmp;
                else
                    vel_x_next = s_tmp;
            end
            ppmds_pkg::ST_P:
            begin
                s_tmp = ppmds_pkg::sat32(ppmds_pkg::sx32(p_sel) + red52);
                if (axis_reg)
                    pos_y_next = s_tmp;
                else
                    pos_x_next = s_tmp;
                axis_next = 1'b1;
            end
            ppmds_pkg::ST_DONE:
                if (!m_valid_reg || m_tready)
                begin
                    out_next     = {vel_y_reg, vel_x_reg, pos_y_reg, pos_x_reg};
                    m_valid_next = 1'b1;
                end
            default:
                s_tmp = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ppmds_pkg::ST_IDLE;
            mode_reg    <= ppmds_pkg::MODE_ACCEL;
            max_acc_reg <= ppmds_pkg::RST_MAX_ACC;
            max_vel_reg <= ppmds_pkg::RST_MAX_VEL;
            kl_reg      <= ppmds_pkg::RST_LIN_GAIN;
            kq_reg      <= ppmds_pkg::RST_QUAD_GAIN;
            thr_reg     <= ppmds_pkg::RST_THRESHOLD;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            wind_x_reg  <= '0;
            wind_y_reg  <= '0;
            axis_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            vel_x_reg   <= vel_x_next;
            vel_y_reg   <= vel_y_next;
            acc_x_reg   <= acc_x_next;
            acc_y_reg   <= acc_y_next;
            wind_x_reg  <= wind_x_next;
            wind_y_reg  <= wind_y_next;
            axis_reg    <= axis_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            // configuration register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ppmds_pkg::REG_MODE:    mode_reg    <= cfg_data[0];
                    ppmds_pkg::REG_MAX_ACC: max_acc_reg <= cfg_data[30:0];
                    ppmds_pkg::REG_MAX_VEL: max_vel_reg <= cfg_data[30:0];
                    ppmds_pkg::REG_LIN:     kl_reg      <= cfg_data[30:0];
                    ppmds_pkg::REG_QUAD:    kq_reg      <= cfg_data[30:0];
                    ppmds_pkg::REG_THR:     thr_reg     <= cfg_data[30:0];
                    default:                mode_reg    <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        wsx_reg   <= wsx_next;
        wsy_reg   <= wsy_next;
        dt_reg    <= dt_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        n_reg     <= n_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        num_reg   <= num_next;
        q_reg     <= q_next;
        alpha_reg <= alpha_next;
        lin_reg   <= lin_next;
        quad_reg  <= quad_next;
        mix_reg   <= mix_next;
        sq_reg    <= sq_next;
        drag_reg  <= drag_next;
        out_reg   <= out_next;
    end

endmodule
